// ----- sv/mrl_pkg.sv -----
`default_nettype none
package mrl_pkg;

  localparam int DEPTH = 8;
  localparam int KEY_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUMP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  typedef struct packed {
    logic capture;
    logic search;
    logic update;
    logic load_out;
  } dp_ctl_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/mrl_ctrl.sv -----
`default_nettype none
module mrl_ctrl
  import mrl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_ctl_t      ctl
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctl.capture  = 1'b0;
    ctl.search   = 1'b0;
    ctl.update   = 1'b0;
    ctl.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        ctl.search = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.update = 1'b1;
        state_nxt  = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/mrl_dp.sv -----
`default_nettype none
module mrl_dp
  import mrl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_ctl_t          ctl,
  output dp_sts_t               sts,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [IDX_W-1:0] in_index,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_changed,
  output logic [KEY_W-1:0]      out_entry_key,
  output logic                  out_entry_valid,
  output logic                  out_head_matches,
  output logic [CNT_W-1:0]      out_count
);

  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [IDX_W-1:0] idx_r;
  logic [KEY_W-1:0] entries_r [DEPTH];
  logic [KEY_W-1:0] entries_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [DEPTH-1:0] match_r;
  logic [DEPTH-1:0] match_nxt;
  logic             res_changed_r;
  logic             res_changed_nxt;
  logic [KEY_W-1:0] res_ekey_r;
  logic [KEY_W-1:0] res_ekey_nxt;
  logic             res_evalid_r;
  logic             res_evalid_nxt;
  logic             out_valid_r;
  logic             out_changed_r;
  logic [KEY_W-1:0] out_ekey_r;
  logic             out_evalid_r;
  logic             out_head_r;
  logic [CNT_W-1:0] out_count_r;

  logic             found;
  logic [IDX_W-1:0] found_pos;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_data;
  logic             idx_lt;
  logic             do_shift;
  logic [IDX_W-1:0] shift_pos;
  logic [KEY_W-1:0] shift_val;
  logic             head_hit;

  assign sts.out_free = !out_valid_r || out_ready;

  // Compare the key with every live entry at once.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      match_nxt[k] = (entries_r[k] == key_r) && (CNT_W'(k) < count_r);
    end
  end

  // The first match below the head.
  always_comb begin
    found_pos = '0;
    for (int k = DEPTH - 1; k > 0; k--) begin
      if (match_r[k]) begin
        found_pos = IDX_W'(k);
      end
    end
  end
  assign found = |match_r[DEPTH-1:1];

  assign rd_addr = (cmd_r == CMD_PUSH) ? found_pos : idx_r;
  assign rd_data = entries_r[rd_addr];
  assign idx_lt  = (CNT_W'(idx_r) < count_r);

  always_comb begin
    entries_nxt     = entries_r;
    count_nxt       = count_r;
    res_changed_nxt = 1'b0;
    res_ekey_nxt    = '0;
    res_evalid_nxt  = 1'b0;
    do_shift        = 1'b0;
    shift_pos       = rd_addr;
    shift_val       = rd_data;
    unique case (cmd_r)
      CMD_PUSH: begin
        if (!match_r[0]) begin
          do_shift        = 1'b1;
          res_changed_nxt = 1'b1;
          if (!found) begin
            shift_pos = IDX_W'(DEPTH - 1);
            shift_val = key_r;
            if (count_r < CNT_W'(DEPTH)) begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
      end
      CMD_BUMP: begin
        if ((idx_r != '0) && idx_lt) begin
          do_shift        = 1'b1;
          res_changed_nxt = 1'b1;
        end
      end
      CMD_APPEND: begin
        if (count_r < CNT_W'(DEPTH)) begin
          entries_nxt[count_r[IDX_W-1:0]] = key_r;
          count_nxt       = count_r + 1'b1;
          res_changed_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (count_r != '0) begin
          count_nxt       = '0;
          res_changed_nxt = 1'b1;
        end
      end
      CMD_READ: begin
        if (idx_lt) begin
          res_ekey_nxt   = rd_data;
          res_evalid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (do_shift) begin
      for (int k = 1; k < DEPTH; k++) begin
        if (IDX_W'(k) <= shift_pos) begin
          entries_nxt[k] = entries_r[k-1];
        end
      end
      entries_nxt[0] = shift_val;
    end
  end

  assign head_hit = (count_r != '0) && (entries_r[0] == key_r);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_command;
      key_r <= in_key;
      idx_r <= in_index;
    end
    if (ctl.search) begin
      match_r <= match_nxt;
    end
    if (ctl.update) begin
      entries_r     <= entries_nxt;
      res_changed_r <= res_changed_nxt;
      res_ekey_r    <= res_ekey_nxt;
      res_evalid_r  <= res_evalid_nxt;
    end
    if (ctl.load_out) begin
      out_changed_r <= res_changed_r;
      out_ekey_r    <= res_ekey_r;
      out_evalid_r  <= res_evalid_r;
      out_head_r    <= head_hit;
      out_count_r   <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.update) begin
        count_r <= count_nxt;
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_changed      = out_changed_r;
  assign out_entry_key    = out_ekey_r;
  assign out_entry_valid  = out_evalid_r;
  assign out_head_matches = out_head_r;
  assign out_count        = out_count_r;

endmodule
`default_nettype wire

// ----- sv/mru_recent_list.sv -----
// Most-recently-used list of up to eight keys; push adds no duplicates, append does not check.
// Input channel (in_valid/in_ready) carries a command, a key and an index:
// push, bump, append, clear or read. Each transfer yields exactly one result
// on the output channel (out_valid/out_ready): the changed flag, the entry
// read, whether it exists, whether the head now equals the key, and the count.
// An item passes through four controller states: capture, a parallel compare
// of the key with all entries, the list update with its shift, and the result
// load. A new item is taken only once the previous one has been loaded.
// The output register holds a result until it is taken; a new input transfer
// is taken meanwhile, but its result waits in the last state while the
// receiver stalls, and no further item is taken until it is loaded.
// Reset empties the list and drops any pending result; entry storage keeps
// its contents, which are never observed beyond the count.
`default_nettype none
module mru_recent_list
  import mrl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [IDX_W-1:0] in_index,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_changed,
  output logic [KEY_W-1:0]      out_entry_key,
  output logic                  out_entry_valid,
  output logic                  out_head_matches,
  output logic [CNT_W-1:0]      out_count
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  mrl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  mrl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_changed      (out_changed),
    .out_entry_key    (out_entry_key),
    .out_entry_valid  (out_entry_valid),
    .out_head_matches (out_head_matches),
    .out_count        (out_count)
  );

endmodule
`default_nettype wire
